FILE: src/tsrr_pkg.sv
// shared types, codes and constants of the thread slot scheduler
`timescale 1ns / 1ps

package tsrr_pkg;

    // slot and field widths
    localparam int THREAD_W      = 7;
    localparam int OP_W          = 3;
    localparam int CODE_W        = 2;
    localparam int DEF_SLOTS     = 128;
    localparam int IDLE_SLOT     = 0;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_SLEEP   = 3'd1;
    localparam logic [OP_W-1:0] OP_WAKEUP  = 3'd2;
    localparam logic [OP_W-1:0] OP_SCHED   = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;

    // per-slot thread status
    localparam logic [1:0] ST_FREE    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    // result status codes
    localparam logic [CODE_W-1:0] RC_OK          = 2'd0;
    localparam logic [CODE_W-1:0] RC_NO_FREE     = 2'd1;
    localparam logic [CODE_W-1:0] RC_IDLE_SLEEP  = 2'd2;
    localparam logic [CODE_W-1:0] RC_NOT_BLOCKED = 2'd3;

    // choice of the next running slot
    localparam logic [1:0] NS_NONE = 2'd0;
    localparam logic [1:0] NS_IDLE = 2'd1;
    localparam logic [1:0] NS_HEAD = 2'd2;
    localparam logic [1:0] NS_LINK = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic              load;
        logic              take_free;
        logic              rd_status;
        logic              rd_link;
        logic              ul_write;
        logic              set_empty;
        logic              append;
        logic              release_slot;
        logic              run;
        logic              chosen_subj;
        logic              emit;
        logic              st_we;
        logic [1:0]        st_val;
        logic              code_we;
        logic [CODE_W-1:0] code;
        logic [1:0]        next_sel;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            no_free;
        logic            cur_idle;
        logic            tgt_ok;
        logic            in_queue;
        logic            st_blocked;
        logic            st_running;
        logic            q_empty;
        logic            q_single;
        logic            subj_tail;
        logic            out_free;
    } t_stat;

endpackage

FILE: src/tsrr_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module tsrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic [WIDTH-1:0]         i_wd,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_ra,
    output logic [WIDTH-1:0]         o_rd
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: src/tsrr_ctrl.sv
// controller state machine sequencing each scheduler operation
`timescale 1ns / 1ps

module tsrr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  tsrr_pkg::t_stat i_stat,
    output tsrr_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_FIND = 4'd2;
    localparam logic [3:0] S_CRD  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_ULR  = 4'd5;
    localparam logic [3:0] S_APP  = 4'd6;
    localparam logic [3:0] S_BLK  = 4'd7;
    localparam logic [3:0] S_WCHK = 4'd8;
    localparam logic [3:0] S_SCH1 = 4'd9;
    localparam logic [3:0] S_SCH2 = 4'd10;
    localparam logic [3:0] S_RUN  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0]     r_state;
    logic [3:0]     n_state;
    logic [3:0]     w_ret;
    tsrr_pkg::t_cmd w_cmd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // state after an unlink: create appends, sleep blocks
    assign w_ret = (i_stat.op == tsrr_pkg::OP_CREATE) ? S_APP : S_BLK;

    // next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    tsrr_pkg::OP_CREATE: begin
                        n_state = S_FIND;
                    end
                    tsrr_pkg::OP_SLEEP: begin
                        if (i_stat.cur_idle) begin
                            w_cmd.code_we = 1'b1;
                            w_cmd.code    = tsrr_pkg::RC_IDLE_SLEEP;
                            n_state       = S_OUT;
                        end else begin
                            w_cmd.rd_status = 1'b1;
                            n_state         = S_CHK;
                        end
                    end
                    tsrr_pkg::OP_WAKEUP: begin
                        if (i_stat.tgt_ok) begin
                            w_cmd.rd_status = 1'b1;
                            n_state         = S_WCHK;
                        end else begin
                            w_cmd.code_we = 1'b1;
                            w_cmd.code    = tsrr_pkg::RC_NOT_BLOCKED;
                            n_state       = S_OUT;
                        end
                    end
                    tsrr_pkg::OP_SCHED: begin
                        w_cmd.rd_status = 1'b1;
                        n_state         = S_SCH1;
                    end
                    tsrr_pkg::OP_RELEASE: begin
                        w_cmd.release_slot = 1'b1;
                        n_state            = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_FIND: begin
                if (i_stat.no_free) begin
                    w_cmd.code_we = 1'b1;
                    w_cmd.code    = tsrr_pkg::RC_NO_FREE;
                    n_state       = S_OUT;
                end else begin
                    w_cmd.take_free = 1'b1;
                    n_state         = S_CRD;
                end
            end
            S_CRD: begin
                w_cmd.rd_status = 1'b1;
                n_state         = S_CHK;
            end
            // take the subject out of the run queue if it is queued
            S_CHK: begin
                if (i_stat.in_queue && !i_stat.q_empty) begin
                    if (i_stat.q_single) begin
                        w_cmd.set_empty = 1'b1;
                        n_state         = w_ret;
                    end else begin
                        w_cmd.rd_link = 1'b1;
                        n_state       = S_ULR;
                    end
                end else begin
                    n_state = w_ret;
                end
            end
            S_ULR: begin
                w_cmd.ul_write = 1'b1;
                n_state        = w_ret;
            end
            S_APP: begin
                w_cmd.st_we       = 1'b1;
                w_cmd.st_val      = tsrr_pkg::ST_READY;
                w_cmd.append      = 1'b1;
                w_cmd.chosen_subj = (i_stat.op == tsrr_pkg::OP_CREATE);
                n_state           = S_OUT;
            end
            S_BLK: begin
                w_cmd.st_we  = 1'b1;
                w_cmd.st_val = tsrr_pkg::ST_BLOCKED;
                n_state      = S_OUT;
            end
            S_WCHK: begin
                if (i_stat.st_blocked) begin
                    n_state = S_APP;
                end else begin
                    w_cmd.code_we = 1'b1;
                    w_cmd.code    = tsrr_pkg::RC_NOT_BLOCKED;
                    n_state       = S_OUT;
                end
            end
            // round-robin choice
            S_SCH1: begin
                n_state = S_RUN;
                if (i_stat.q_empty) begin
                    w_cmd.next_sel = tsrr_pkg::NS_IDLE;
                end else if (i_stat.cur_idle) begin
                    w_cmd.next_sel = tsrr_pkg::NS_HEAD;
                    w_cmd.st_we    = 1'b1;
                    w_cmd.st_val   = tsrr_pkg::ST_READY;
                end else if (!i_stat.st_running) begin
                    w_cmd.next_sel = tsrr_pkg::NS_HEAD;
                end else if (i_stat.subj_tail) begin
                    w_cmd.next_sel = tsrr_pkg::NS_HEAD;
                    w_cmd.st_we    = 1'b1;
                    w_cmd.st_val   = tsrr_pkg::ST_READY;
                end else begin
                    w_cmd.rd_link = 1'b1;
                    w_cmd.st_we   = 1'b1;
                    w_cmd.st_val  = tsrr_pkg::ST_READY;
                    n_state       = S_SCH2;
                end
            end
            S_SCH2: begin
                w_cmd.next_sel = tsrr_pkg::NS_LINK;
                n_state        = S_RUN;
            end
            S_RUN: begin
                w_cmd.run = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_s_tready = (r_state == S_IDLE);

endmodule

FILE: src/tsrr_dp.sv
// datapath: slot map, status and link memories, queue pointers, result register
`timescale 1ns / 1ps

module tsrr_dp #(
    parameter int THREAD_SLOTS = tsrr_pkg::DEF_SLOTS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [tsrr_pkg::IN_DATA_W-1:0]       i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [tsrr_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    input  tsrr_pkg::t_cmd                       i_cmd,
    output tsrr_pkg::t_stat                      o_stat
);

    localparam int TW   = tsrr_pkg::THREAD_W;
    localparam int AW   = $clog2(THREAD_SLOTS);
    localparam int NGRP = (THREAD_SLOTS + 7) / 8;

    logic [tsrr_pkg::OP_W-1:0]   w_op_in;
    logic [TW-1:0]               w_tgt_in;
    logic [tsrr_pkg::OP_W-1:0]   r_op;
    logic [TW-1:0]               r_tgt;
    logic [TW-1:0]               r_subj;
    logic [TW-1:0]               r_next;
    logic [TW-1:0]               r_head;
    logic [TW-1:0]               r_tail;
    logic                        r_empty;
    logic [TW-1:0]               r_run;
    logic [THREAD_SLOTS-1:0]     r_alloc;
    logic [THREAD_SLOTS-1:0]     r_st_vld;
    logic [AW-1:0]               r_rd_a;
    logic [TW-1:0]               r_chosen;
    logic [tsrr_pkg::CODE_W-1:0] r_code;
    logic                        r_out_vld;
    logic [tsrr_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [NGRP*8-1:0]           w_pad;
    logic [2:0]                  w_glow [NGRP];
    logic [2:0]                  r_glow [NGRP];
    logic [NGRP-1:0]             r_gfree;
    logic [TW-1:0]               w_found;

    logic [1:0]                  w_st_q;
    logic [1:0]                  w_st;
    logic [TW-1:0]               w_nxt_q;
    logic [TW-1:0]               w_prv_q;
    logic                        w_tgt_ok;

    logic                        w_st_we;
    logic [AW-1:0]               w_st_wa;
    logic [1:0]                  w_st_wd;
    logic                        w_nxt_we;
    logic [AW-1:0]               w_nxt_wa;
    logic [TW-1:0]               w_nxt_wd;
    logic                        w_prv_we;
    logic [AW-1:0]               w_prv_wa;
    logic [TW-1:0]               w_prv_wd;

    // input item fields
    assign w_op_in  = i_s_tdata[tsrr_pkg::OP_W-1:0];
    assign w_tgt_in = i_s_tdata[tsrr_pkg::OP_W +: TW];

    assign w_tgt_ok = ({1'b0, r_tgt} < (TW + 1)'(THREAD_SLOTS));

    // free slot search, first level: per group of eight
    always_comb begin
        w_pad = '1;
        w_pad[THREAD_SLOTS-1:0] = r_alloc;
        for (int g = 0; g < NGRP; g++) begin
            w_glow[g] = 3'd0;
            for (int b = 7; b >= 0; b--) begin
                if (!w_pad[g*8+b]) begin
                    w_glow[g] = 3'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_gfree[g] <= ~&w_pad[g*8 +: 8];
            r_glow[g]  <= w_glow[g];
        end
    end

    // free slot search, second level: lowest group with a free slot
    always_comb begin
        w_found = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_gfree[g]) begin
                w_found = TW'(g * 8) | TW'(r_glow[g]);
            end
        end
    end

    // status read, unwritten entries read as their reset value
    assign w_st = r_st_vld[r_rd_a] ? w_st_q :
                  ((r_rd_a == AW'(tsrr_pkg::IDLE_SLOT)) ? tsrr_pkg::ST_RUNNING
                                                         : tsrr_pkg::ST_FREE);

    // memory write ports
    always_comb begin
        w_st_we  = i_cmd.st_we | i_cmd.run;
        w_st_wa  = i_cmd.run ? r_next[AW-1:0] : r_subj[AW-1:0];
        w_st_wd  = i_cmd.run ? tsrr_pkg::ST_RUNNING : i_cmd.st_val;
        w_nxt_we = 1'b0;
        w_nxt_wa = r_tail[AW-1:0];
        w_nxt_wd = r_subj;
        w_prv_we = 1'b0;
        w_prv_wa = r_subj[AW-1:0];
        w_prv_wd = r_tail;
        if (i_cmd.ul_write) begin
            w_nxt_we = (r_head != r_subj);
            w_nxt_wa = w_prv_q[AW-1:0];
            w_nxt_wd = w_nxt_q;
            w_prv_we = (r_tail != r_subj);
            w_prv_wa = w_nxt_q[AW-1:0];
            w_prv_wd = w_prv_q;
        end else if (i_cmd.append && !r_empty) begin
            w_nxt_we = 1'b1;
            w_prv_we = 1'b1;
        end
    end

    tsrr_ram #(.WIDTH(2), .DEPTH(THREAD_SLOTS)) u_status_ram (
        .i_clk (i_clk),
        .i_we  (w_st_we),
        .i_wa  (w_st_wa),
        .i_wd  (w_st_wd),
        .i_re  (i_cmd.rd_status),
        .i_ra  (r_subj[AW-1:0]),
        .o_rd  (w_st_q)
    );

    tsrr_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_next_ram (
        .i_clk (i_clk),
        .i_we  (w_nxt_we),
        .i_wa  (w_nxt_wa),
        .i_wd  (w_nxt_wd),
        .i_re  (i_cmd.rd_link),
        .i_ra  (r_subj[AW-1:0]),
        .o_rd  (w_nxt_q)
    );

    tsrr_ram #(.WIDTH(TW), .DEPTH(THREAD_SLOTS)) u_prev_ram (
        .i_clk (i_clk),
        .i_we  (w_prv_we),
        .i_wa  (w_prv_wa),
        .i_wd  (w_prv_wd),
        .i_re  (i_cmd.rd_link),
        .i_ra  (r_subj[AW-1:0]),
        .o_rd  (w_prv_q)
    );

    // operation payload and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= w_op_in;
            r_tgt    <= w_tgt_in;
            r_subj   <= (w_op_in inside {tsrr_pkg::OP_SLEEP, tsrr_pkg::OP_SCHED})
                        ? r_run : w_tgt_in;
            r_chosen <= '0;
            r_code   <= tsrr_pkg::RC_OK;
        end
        if (i_cmd.take_free) begin
            r_subj <= w_found;
        end
        if (i_cmd.rd_status) begin
            r_rd_a <= r_subj[AW-1:0];
        end
        if (i_cmd.code_we) begin
            r_code <= i_cmd.code;
        end
        if (i_cmd.chosen_subj) begin
            r_chosen <= r_subj;
        end
        if (i_cmd.run) begin
            r_chosen <= r_next;
        end
        case (i_cmd.next_sel)
            tsrr_pkg::NS_IDLE: r_next <= TW'(tsrr_pkg::IDLE_SLOT);
            tsrr_pkg::NS_HEAD: r_next <= r_head;
            tsrr_pkg::NS_LINK: r_next <= w_nxt_q;
            default: ;
        endcase
    end

    // queue pointers, running slot, slot map and status valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_run    <= TW'(tsrr_pkg::IDLE_SLOT);
            r_alloc  <= THREAD_SLOTS'(1) << tsrr_pkg::IDLE_SLOT;
            r_st_vld <= '0;
        end else begin
            if (i_cmd.set_empty) begin
                r_empty <= 1'b1;
            end
            if (i_cmd.ul_write) begin
                if (r_head == r_subj) begin
                    r_head <= w_nxt_q;
                end
                if (r_tail == r_subj) begin
                    r_tail <= w_prv_q;
                end
            end
            if (i_cmd.append) begin
                r_tail <= r_subj;
                if (r_empty) begin
                    r_head  <= r_subj;
                    r_empty <= 1'b0;
                end
            end
            if (i_cmd.run) begin
                r_run <= r_next;
            end
            if (i_cmd.take_free) begin
                r_alloc[w_found[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.release_slot && w_tgt_ok &&
                (r_tgt != TW'(tsrr_pkg::IDLE_SLOT))) begin
                r_alloc[r_tgt[AW-1:0]] <= 1'b0;
            end
            if (w_st_we) begin
                r_st_vld[w_st_wa] <= 1'b1;
            end
        end
    end

    // result register, free again once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {r_run, r_code, r_chosen};
        end
    end

    // status to controller
    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.no_free    = ~|r_gfree;
        o_stat.cur_idle   = (r_run == TW'(tsrr_pkg::IDLE_SLOT));
        o_stat.tgt_ok     = w_tgt_ok;
        o_stat.in_queue   = (r_subj != TW'(tsrr_pkg::IDLE_SLOT)) &&
                            ((w_st == tsrr_pkg::ST_READY) ||
                             (w_st == tsrr_pkg::ST_RUNNING));
        o_stat.st_blocked = (w_st == tsrr_pkg::ST_BLOCKED);
        o_stat.st_running = (w_st == tsrr_pkg::ST_RUNNING);
        o_stat.q_empty    = r_empty;
        o_stat.q_single   = (r_head == r_subj) && (r_tail == r_subj);
        o_stat.subj_tail  = (r_tail == r_subj);
        o_stat.out_free   = !r_out_vld || i_m_tready;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: src/thread_slot_round_robin_scheduler.sv
// top level of the round-robin thread slot scheduler
//
//  channel  direction  handshake               tdata fields (low bit up)
//  s        in         i_s_tvalid/o_s_tready   operation[2:0] target_thread[9:3]
//  m        out        o_m_tvalid/i_m_tready   chosen_thread[6:0] status[8:7]
//                                              running_now[15:9]
//
// one operation at a time; the time from acceptance to result is set by the
// dependent status and link memory reads of an unlink followed by an append
// (create is the longest path); the next item can be taken in the cycle after
// the result is issued.
// reset: synchronous, active low; no clearing pass, status entries carry
// valid bits. a result waiting in the output register does not stop the
// next item from being accepted; only a second result waits for it.
`timescale 1ns / 1ps

module thread_slot_round_robin_scheduler #(
    parameter int THREAD_SLOTS = tsrr_pkg::DEF_SLOTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // operation[2:0], target_thread[9:3], zero fill above
    input  logic [tsrr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // chosen_thread[6:0], status[8:7], running_now[15:9]
    output logic [tsrr_pkg::OUT_DATA_W-1:0]  o_m_tdata
);

    tsrr_pkg::t_cmd  w_cmd;
    tsrr_pkg::t_stat w_stat;

    // operation sequencer
    tsrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // scheduler state and memories
    tsrr_dp #(.THREAD_SLOTS(THREAD_SLOTS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

endmodule

FILE: test/thread_slot_round_robin_scheduler_tb.sv
// self-checking testbench of the round-robin thread slot scheduler
`timescale 1ns / 1ps

module thread_slot_round_robin_scheduler_tb;

    localparam int SLOTS     = tsrr_pkg::DEF_SLOTS;
    localparam int TW        = tsrr_pkg::THREAD_W;
    localparam int OW        = tsrr_pkg::OP_W;
    localparam int LIMIT     = 400000;
    localparam int PER_PHASE = 220;

    // one outcome of an operation
    typedef struct packed {
        logic [TW-1:0]               chosen;
        logic [tsrr_pkg::CODE_W-1:0] code;
        logic [TW-1:0]               running;
    } t_outcome;

    // one row of the directed table
    typedef struct {
        logic [OW-1:0] op;
        logic [TW-1:0] tgt;
        bit            typed;
        t_outcome      want;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [tsrr_pkg::IN_DATA_W-1:0]  i_s_tdata;   // operation, target_thread, zero fill
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [tsrr_pkg::OUT_DATA_W-1:0] o_m_tdata;   // chosen_thread, status, running_now

    thread_slot_round_robin_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // shadow copy of the scheduler state
    bit            sh_alloc [SLOTS];
    logic [1:0]    sh_state [SLOTS];
    logic [TW-1:0] sh_fwd   [SLOTS];
    logic [TW-1:0] sh_back  [SLOTS];
    logic [TW-1:0] sh_head, sh_tail, sh_run;
    bit            sh_empty;

    t_outcome outcome_q[$];
    bit       row_typed;
    t_outcome row_want;
    int       sender_idle_pct, recv_stall_pct, hold_cycles;
    int       errors, items_in, results_out, cycles;
    int       n_nofree, n_idlesleep, n_notblocked, n_sched;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit queued(int s);
        return s != tsrr_pkg::IDLE_SLOT &&
               (sh_state[s] == tsrr_pkg::ST_READY || sh_state[s] == tsrr_pkg::ST_RUNNING);
    endfunction

    function automatic void unlink_slot(int s);
        logic [TW-1:0] f, b;
        if (sh_empty) return;
        if (sh_head == s && sh_tail == s) begin
            sh_empty = 1;
            return;
        end
        f = sh_fwd[s];
        b = sh_back[s];
        if (sh_head == s) sh_head = f;
        else sh_fwd[b] = f;
        if (sh_tail == s) sh_tail = b;
        else sh_back[f] = b;
    endfunction

    function automatic void append_slot(int s);
        if (sh_empty) begin
            sh_head = TW'(s);
            sh_tail = TW'(s);
            sh_empty = 0;
            return;
        end
        sh_fwd[sh_tail] = TW'(s);
        sh_back[s] = sh_tail;
        sh_tail = TW'(s);
    endfunction

    function automatic void reset_shadow();
        for (int i = 0; i < SLOTS; i++) begin
            sh_alloc[i] = 0;
            sh_state[i] = tsrr_pkg::ST_FREE;
            sh_fwd[i] = '0;
            sh_back[i] = '0;
        end
        sh_alloc[tsrr_pkg::IDLE_SLOT] = 1;
        sh_state[tsrr_pkg::IDLE_SLOT] = tsrr_pkg::ST_RUNNING;
        sh_head = '0;
        sh_tail = '0;
        sh_empty = 1;
        sh_run = TW'(tsrr_pkg::IDLE_SLOT);
    endfunction

    // advance the shadow state by one operation and give its outcome
    function automatic t_outcome schedule_step(logic [OW-1:0] op,
                                               logic [TW-1:0] tgt);
        t_outcome r;
        int s, cur, pick;
        r = '0;
        cur = sh_run;
        case (op)
            tsrr_pkg::OP_CREATE: begin
                for (s = 0; s < SLOTS; s++) if (!sh_alloc[s]) break;
                if (s >= SLOTS) begin
                    r.code = tsrr_pkg::RC_NO_FREE;
                end else begin
                    sh_alloc[s] = 1;
                    if (queued(s)) unlink_slot(s);
                    sh_state[s] = tsrr_pkg::ST_READY;
                    append_slot(s);
                    r.chosen = TW'(s);
                end
            end
            tsrr_pkg::OP_SLEEP: begin
                if (cur == tsrr_pkg::IDLE_SLOT) begin
                    r.code = tsrr_pkg::RC_IDLE_SLEEP;
                end else begin
                    if (queued(cur)) unlink_slot(cur);
                    sh_state[cur] = tsrr_pkg::ST_BLOCKED;
                end
            end
            tsrr_pkg::OP_WAKEUP: begin
                if (tgt < SLOTS && sh_state[tgt] == tsrr_pkg::ST_BLOCKED) begin
                    sh_state[tgt] = tsrr_pkg::ST_READY;
                    append_slot(tgt);
                end else begin
                    r.code = tsrr_pkg::RC_NOT_BLOCKED;
                end
            end
            tsrr_pkg::OP_SCHED: begin
                if (sh_empty) begin
                    pick = tsrr_pkg::IDLE_SLOT;
                end else if (cur == tsrr_pkg::IDLE_SLOT) begin
                    pick = sh_head;
                    sh_state[cur] = tsrr_pkg::ST_READY;
                end else if (sh_state[cur] != tsrr_pkg::ST_RUNNING) begin
                    pick = sh_head;
                end else begin
                    pick = (cur == sh_tail) ? sh_head : sh_fwd[cur];
                    sh_state[cur] = tsrr_pkg::ST_READY;
                end
                sh_state[pick] = tsrr_pkg::ST_RUNNING;
                sh_run = TW'(pick);
                r.chosen = TW'(pick);
            end
            tsrr_pkg::OP_RELEASE: begin
                if (tgt < SLOTS && tgt != tsrr_pkg::IDLE_SLOT) sh_alloc[tgt] = 0;
            end
            default: ;
        endcase
        r.running = sh_run;
        return r;
    endfunction

    // accepted input items: predict and queue the outcome
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            t_outcome p;
            p = schedule_step(i_s_tdata[2:0], i_s_tdata[9:3]);
            outcome_q.push_back(row_typed ? row_want : p);
            items_in++;
            case (p.code)
                tsrr_pkg::RC_NO_FREE:     n_nofree++;
                tsrr_pkg::RC_IDLE_SLEEP:  n_idlesleep++;
                tsrr_pkg::RC_NOT_BLOCKED: n_notblocked++;
                default: ;
            endcase
            if (i_s_tdata[2:0] == tsrr_pkg::OP_SCHED) n_sched++;
        end
    end

    // accepted results: compare with the oldest outcome
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_outcome got, w;
            got = {o_m_tdata[6:0], o_m_tdata[8:7], o_m_tdata[15:9]};
            results_out++;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %h", o_m_tdata);
            end else begin
                w = outcome_q.pop_front();
                if (got !== w) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: chosen %0d/%0d code %0d/%0d running %0d/%0d (exp/act)",
                                 w.chosen, got.chosen, w.code, got.code,
                                 w.running, got.running);
                end
            end
        end
    end

    // receiver: random stalls and long hold-offs
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("thread_slot_round_robin_scheduler_tb NOT OK");
            $finish;
        end
    end

    // offer one item and wait for its acceptance
    task automatic send_item(logic [OW-1:0] op, logic [TW-1:0] tgt,
                             bit typed = 0, t_outcome want = '0);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, tgt, op};
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // blocked slot if any, else a random one
    function automatic logic [TW-1:0] some_blocked();
        int b;
        b = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
            if (sh_state[(b + i) % SLOTS] == tsrr_pkg::ST_BLOCKED)
                return TW'((b + i) % SLOTS);
        return TW'($urandom_range(127));
    endfunction

    // allocated non-idle slot if any, else a random one
    function automatic logic [TW-1:0] some_allocated();
        int b;
        b = $urandom_range(SLOTS - 1);
        for (int i = 0; i < SLOTS; i++)
            if ((b + i) % SLOTS != tsrr_pkg::IDLE_SLOT && sh_alloc[(b + i) % SLOTS])
                return TW'((b + i) % SLOTS);
        return TW'($urandom_range(127));
    endfunction

    task automatic random_item();
        int w;
        w = $urandom_range(99);
        if (w < 24)      send_item(tsrr_pkg::OP_CREATE, TW'($urandom_range(127)));
        else if (w < 38) send_item(tsrr_pkg::OP_SLEEP, TW'($urandom_range(127)));
        else if (w < 56) send_item(tsrr_pkg::OP_WAKEUP,
                                   ($urandom_range(9) < 7) ? some_blocked()
                                                           : TW'($urandom_range(127)));
        else if (w < 86) send_item(tsrr_pkg::OP_SCHED, TW'($urandom_range(127)));
        else if (w < 97) send_item(tsrr_pkg::OP_RELEASE,
                                   ($urandom_range(9) < 7) ? some_allocated()
                                                           : TW'($urandom_range(127)));
        else             send_item(OW'($urandom_range(7, 5)), TW'($urandom_range(127)));
    endtask

    t_row dir_tab[] = '{
        '{tsrr_pkg::OP_SCHED,   7'd0,   1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{tsrr_pkg::OP_SLEEP,   7'd0,   1, '{7'd0, tsrr_pkg::RC_IDLE_SLEEP, 7'd0}},
        '{tsrr_pkg::OP_WAKEUP,  7'd0,   1, '{7'd0, tsrr_pkg::RC_NOT_BLOCKED, 7'd0}},
        '{tsrr_pkg::OP_WAKEUP,  7'd127, 1, '{7'd0, tsrr_pkg::RC_NOT_BLOCKED, 7'd0}},
        '{tsrr_pkg::OP_RELEASE, 7'd0,   1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{tsrr_pkg::OP_RELEASE, 7'd127, 1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{3'd5,                 7'd127, 1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{3'd6,                 7'd85,  1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{3'd7,                 7'd42,  1, '{7'd0, tsrr_pkg::RC_OK, 7'd0}},
        '{tsrr_pkg::OP_CREATE,  7'd127, 1, '{7'd1, tsrr_pkg::RC_OK, 7'd0}},
        '{tsrr_pkg::OP_CREATE,  7'd0,   1, '{7'd2, tsrr_pkg::RC_OK, 7'd0}},
        '{tsrr_pkg::OP_CREATE,  7'd0,   0, '0},
        '{tsrr_pkg::OP_SCHED,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SCHED,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SLEEP,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SCHED,   7'd0,   0, '0},
        '{tsrr_pkg::OP_WAKEUP,  7'd2,   0, '0},
        '{tsrr_pkg::OP_WAKEUP,  7'd2,   0, '0},
        '{tsrr_pkg::OP_RELEASE, 7'd1,   0, '0},
        '{tsrr_pkg::OP_CREATE,  7'd0,   0, '0},
        '{tsrr_pkg::OP_SCHED,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SLEEP,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SLEEP,   7'd0,   0, '0},
        '{tsrr_pkg::OP_SCHED,   7'd0,   0, '0}
    };

    // main sequence
    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        row_typed = 0;
        row_want = '0;
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        errors = 0; items_in = 0; results_out = 0; cycles = 0;
        n_nofree = 0; n_idlesleep = 0; n_notblocked = 0; n_sched = 0;
        reset_shadow();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tab[i])
            send_item(dir_tab[i].op, dir_tab[i].tgt, dir_tab[i].typed, dir_tab[i].want);
        row_typed <= 0;
        drain();

        // idling phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 69) : 0;
            recv_stall_pct  = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 69) : 0;
            if (ph == 0) begin
                // fill every slot, run into no free slot, then free many again
                repeat (SLOTS + 4) send_item(tsrr_pkg::OP_CREATE, TW'($urandom_range(127)));
                repeat (60) send_item(tsrr_pkg::OP_SCHED, TW'($urandom_range(127)));
                repeat (40) send_item(tsrr_pkg::OP_RELEASE, some_allocated());
            end
            if (ph == 2) hold_cycles = 300;
            for (int n = 0; n < PER_PHASE; n++) begin
                random_item();
                if (n == PER_PHASE / 2) drain();
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("%0d items, %0d results; %0d schedules, %0d no-free,",
                 items_in, results_out, n_sched, n_nofree);
        $display("%0d idle-sleep, %0d not-blocked; covered full slot table, long receiver",
                 n_idlesleep, n_notblocked);
        $display("hold-off and four idling phases");
        if (errors == 0 && outcome_q.size() == 0) begin
            $display("thread_slot_round_robin_scheduler_tb OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, outcome_q.size());
            $display("thread_slot_round_robin_scheduler_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: thread_slot_round_robin_scheduler.f
src/tsrr_pkg.sv
src/tsrr_ram.sv
src/tsrr_ctrl.sv
src/tsrr_dp.sv
src/thread_slot_round_robin_scheduler.sv
test/thread_slot_round_robin_scheduler_tb.sv
